/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property check, sampled on the rising clock edge, off while reset is low.
`define HP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("hp assertion failed");

// Condition that must never be seen.
`define HP_NEVER(lbl, clk, rst_n, cond) \
	`HP_ASSERT(lbl, clk, rst_n, !(cond))

`endif

/* rtl/core/hp_pkg.sv */
package hp_pkg;

	localparam int SLOTS     = 64;
	localparam int GEN_WIDTH = 16;
	localparam int REF_WIDTH = 16;
	localparam int KEY_WIDTH = 64;
	localparam int IDX_W     = $clog2(SLOTS);
	localparam int CNT_W     = $clog2(SLOTS + 1);

	typedef logic [KEY_WIDTH-1:0] key_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [GEN_WIDTH-1:0] gen_t;
	typedef logic [REF_WIDTH-1:0] ref_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [1:0]           kind_t;
	typedef logic [2:0]           status_t;

	localparam kind_t KIND_GET     = 2'd0;
	localparam kind_t KIND_RETAIN  = 2'd1;
	localparam kind_t KIND_RELEASE = 2'd2;

	localparam status_t ST_REUSED   = 3'd0;
	localparam status_t ST_CREATED  = 3'd1;
	localparam status_t ST_RETAINED = 3'd2;
	localparam status_t ST_KEPT     = 3'd3;
	localparam status_t ST_FREED    = 3'd4;
	localparam status_t ST_INVALID  = 3'd5;
	localparam status_t ST_FULL     = 3'd6;

	// request token that walks the cell row
	typedef struct packed {
		logic    valid;
		kind_t   kind;
		key_t    key;
		idx_t    idx;
		gen_t    gen;
		logic    hit;
		status_t status;
		idx_t    res_idx;
		gen_t    res_gen;
		idx_t    cand_idx;
		gen_t    cand_gen;
	} tok_t;

	// slot fill broadcast from the controller
	typedef struct packed {
		logic en;
		idx_t idx;
		key_t key;
		logic fresh;
	} wr_t;

	function automatic ref_t ref_bump(ref_t c);
		return (c == '1) ? c : c + ref_t'(1);
	endfunction

endpackage

/* rtl/core/hp_if.sv */
interface hp_in_if;
	logic              valid;
	logic              ready;
	hp_pkg::kind_t     kind;
	hp_pkg::key_t      desc_key;
	hp_pkg::idx_t      slot_index;
	hp_pkg::gen_t      slot_generation;

	modport source(output valid, kind, desc_key, slot_index, slot_generation, input ready);
	modport sink(input valid, kind, desc_key, slot_index, slot_generation, output ready);
endinterface

interface hp_out_if;
	logic              valid;
	logic              ready;
	hp_pkg::status_t   status;
	hp_pkg::idx_t      out_index;
	hp_pkg::gen_t      out_generation;
	hp_pkg::cnt_t      live_count;

	modport source(output valid, status, out_index, out_generation, live_count, input ready);
	modport sink(input valid, status, out_index, out_generation, live_count, output ready);
endinterface

/* rtl/core/hp_cell.sv */
module hp_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  hp_pkg::idx_t my_idx,
	input  hp_pkg::wr_t  wr,
	input  hp_pkg::tok_t tin,
	output hp_pkg::tok_t tout
);
	import hp_pkg::*;

	key_t key_q;
	logic live_q;
	gen_t gen_q;
	ref_t rc_q;
	tok_t tok_s1;

	key_t key_d;
	logic live_d;
	gen_t gen_d;
	ref_t rc_d;
	tok_t tok_d;

	always_comb begin
		key_d  = key_q;
		live_d = live_q;
		gen_d  = gen_q;
		rc_d   = rc_q;
		tok_d  = tin;
		if (wr.en && wr.idx == my_idx) begin
			key_d  = wr.key;
			live_d = 1'b1;
			rc_d   = ref_t'(1);
			if (wr.fresh) begin
				gen_d = '0;
			end
		end else if (tin.valid) begin
			case (tin.kind)
				KIND_GET: begin
					if (tin.cand_idx == my_idx) begin
						tok_d.cand_gen = gen_q;
					end
					if (!tin.hit && live_q && key_q == tin.key) begin
						tok_d.hit     = 1'b1;
						tok_d.status  = ST_REUSED;
						tok_d.res_idx = my_idx;
						tok_d.res_gen = gen_q;
						rc_d          = ref_bump(rc_q);
					end
				end
				KIND_RETAIN: begin
					if (tin.idx == my_idx && live_q && gen_q == tin.gen) begin
						tok_d.hit     = 1'b1;
						tok_d.status  = ST_RETAINED;
						tok_d.res_idx = my_idx;
						tok_d.res_gen = gen_q;
						rc_d          = ref_bump(rc_q);
					end
				end
				KIND_RELEASE: begin
					if (tin.idx == my_idx && live_q && gen_q == tin.gen) begin
						tok_d.hit     = 1'b1;
						tok_d.res_idx = my_idx;
						tok_d.res_gen = tin.gen;
						if (rc_q > ref_t'(1)) begin
							tok_d.status = ST_KEPT;
							rc_d         = rc_q - ref_t'(1);
						end else begin
							tok_d.status = ST_FREED;
							rc_d         = '0;
							key_d        = '0;
							live_d       = 1'b0;
							gen_d        = gen_q + gen_t'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			live_q <= 1'b0;
			gen_q  <= '0;
			rc_q   <= '0;
			tok_s1 <= '0;
		end else begin
			key_q  <= key_d;
			live_q <= live_d;
			gen_q  <= gen_d;
			rc_q   <= rc_d;
			tok_s1 <= tok_d;
		end
	end

	assign tout = tok_s1;

endmodule

/* rtl/core/dedup_refcount_handle_pool_unit.sv */
// Handle pool with key dedup and reference counts. Each of the SLOTS slots lives in its
// own cell; a request walks the row of cells one cell per cycle. An accepted item goes
// from the request register to the launch register, through every cell of the row, into
// the end-of-row token register and then to the output register at commit; the next item
// is accepted once the unit is back in idle after that commit. One item is in flight at a
// time; the result sits in an output register and the commit of the next item waits only
// if that register is still full.
module dedup_refcount_handle_pool_unit (
	input  logic clk,
	input  logic arst_n,
	hp_in_if.sink    in,
	hp_out_if.source out
);
	import hp_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN, S_DONE} state_t;

	state_t  state_q;
	tok_t    launch_q;
	tok_t    tok_q;
	tok_t    req_q;
	logic    cand_ok_q;
	logic    cand_fresh_q;
	idx_t    pop_q;
	cnt_t    free_top_q;
	cnt_t    fresh_q;
	cnt_t    live_q;
	wr_t     wr_q;
	logic    res_valid_q;
	status_t res_status_q;
	idx_t    res_idx_q;
	gen_t    res_gen_q;
	cnt_t    res_live_q;

	idx_t    stack_mem [SLOTS];
	tok_t    chain [SLOTS+1];

	logic    accept;
	logic    can_commit;
	status_t c_status;
	idx_t    c_idx;
	gen_t    c_gen;
	wr_t     c_wr;
	logic    c_push;
	cnt_t    c_live;
	cnt_t    c_top;
	cnt_t    c_fresh;

	assign accept     = in.valid && in.ready;
	assign in.ready   = (state_q == S_IDLE);
	assign can_commit = (state_q == S_DONE) && (!res_valid_q || out.ready);

	assign chain[0] = launch_q;

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		hp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.my_idx (idx_t'(g)),
			.wr     (wr_q),
			.tin    (chain[g]),
			.tout   (chain[g+1])
		);
	end

	// free stack: pop address is read on accept, push lands on commit
	always_ff @(posedge clk) begin
		if (accept) begin
			pop_q <= stack_mem[IDX_W'(free_top_q - cnt_t'(1))];
		end
		if (can_commit && c_push) begin
			stack_mem[free_top_q[IDX_W-1:0]] <= tok_q.res_idx;
		end
	end

	always_comb begin
		c_status = ST_INVALID;
		c_idx    = tok_q.idx;
		c_gen    = tok_q.gen;
		c_wr     = '0;
		c_push   = 1'b0;
		c_live   = live_q;
		c_top    = free_top_q;
		c_fresh  = fresh_q;
		case (tok_q.kind)
			KIND_GET: begin
				if (tok_q.hit) begin
					c_status = ST_REUSED;
					c_idx    = tok_q.res_idx;
					c_gen    = tok_q.res_gen;
				end else if (cand_ok_q) begin
					c_status   = ST_CREATED;
					c_idx      = tok_q.cand_idx;
					c_gen      = cand_fresh_q ? '0 : tok_q.cand_gen;
					c_wr.en    = 1'b1;
					c_wr.idx   = tok_q.cand_idx;
					c_wr.key   = tok_q.key;
					c_wr.fresh = cand_fresh_q;
					c_live     = live_q + cnt_t'(1);
					if (cand_fresh_q) begin
						c_fresh = fresh_q + cnt_t'(1);
					end else begin
						c_top = free_top_q - cnt_t'(1);
					end
				end else begin
					c_status = ST_FULL;
					c_idx    = '0;
					c_gen    = '0;
				end
			end
			KIND_RETAIN, KIND_RELEASE: begin
				if (tok_q.hit) begin
					c_status = tok_q.status;
					c_idx    = tok_q.res_idx;
					c_gen    = tok_q.res_gen;
					if (tok_q.status == ST_FREED) begin
						if (free_top_q < cnt_t'(SLOTS)) begin
							c_push = 1'b1;
							c_top  = free_top_q + cnt_t'(1);
						end
						if (live_q != '0) begin
							c_live = live_q - cnt_t'(1);
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			launch_q     <= '0;
			tok_q        <= '0;
			req_q        <= '0;
			cand_ok_q    <= 1'b0;
			cand_fresh_q <= 1'b0;
			free_top_q   <= '0;
			fresh_q      <= '0;
			live_q       <= '0;
			wr_q         <= '0;
			res_valid_q  <= 1'b0;
			res_status_q <= ST_REUSED;
			res_idx_q    <= '0;
			res_gen_q    <= '0;
			res_live_q   <= '0;
		end else begin
			launch_q.valid <= 1'b0;
			wr_q.en        <= 1'b0;
			if (res_valid_q && out.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q          <= '0;
						req_q.valid    <= 1'b1;
						req_q.kind     <= in.kind;
						req_q.key      <= in.desc_key;
						req_q.idx      <= in.slot_index;
						req_q.gen      <= in.slot_generation;
						cand_ok_q      <= (free_top_q != '0) || (fresh_q < cnt_t'(SLOTS));
						cand_fresh_q   <= (free_top_q == '0);
						state_q        <= S_LOAD;
					end
				end
				S_LOAD: begin
					launch_q          <= req_q;
					launch_q.cand_idx <= cand_fresh_q ? fresh_q[IDX_W-1:0] : pop_q;
					state_q           <= S_RUN;
				end
				S_RUN: begin
					if (chain[SLOTS].valid) begin
						tok_q   <= chain[SLOTS];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (can_commit) begin
						res_valid_q  <= 1'b1;
						res_status_q <= c_status;
						res_idx_q    <= c_idx;
						res_gen_q    <= c_gen;
						res_live_q   <= c_live;
						wr_q         <= c_wr;
						live_q       <= c_live;
						free_top_q   <= c_top;
						fresh_q      <= c_fresh;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out.valid          = res_valid_q;
	assign out.status         = res_status_q;
	assign out.out_index      = res_idx_q;
	assign out.out_generation = res_gen_q;
	assign out.live_count     = res_live_q;

endmodule

/* rtl/core/hp_checker.sv */
`include "assert_macros.svh"

module hp_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input hp_pkg::status_t out_status,
	input hp_pkg::cnt_t    out_live_count
);
	import hp_pkg::*;

	`HP_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)
	`HP_NEVER(a_status_code, clk, arst_n, out_valid && out_status > ST_FULL)
	`HP_NEVER(a_live_bound, clk, arst_n, out_valid && out_live_count > cnt_t'(SLOTS))
	`HP_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && in_ready |=> !in_ready)

endmodule

bind dedup_refcount_handle_pool_unit hp_checker u_hp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in.valid),
	.in_ready       (in.ready),
	.out_valid      (out.valid),
	.out_ready      (out.ready),
	.out_status     (out.status),
	.out_live_count (out.live_count)
);

/* sim/dedup_refcount_handle_pool_unit_tb.sv */
`timescale 1ns / 100ps

module dedup_refcount_handle_pool_unit_tb;
	import hp_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 2 * SLOTS + 16;

	typedef struct {
		status_t status;
		idx_t    index;
		gen_t    generation;
		cnt_t    live;
	} handle_result_t;

	// shadow of the pool, advanced at each accepted request
	class pool_scoreboard;
		key_t  slot_key[SLOTS];
		bit    slot_live[SLOTS];
		gen_t  slot_gen[SLOTS];
		ref_t  slot_refs[SLOTS];
		idx_t  free_slots[SLOTS];
		int    free_depth;
		int    fresh_slot;
		int    live_slots;
		int    errors;
		handle_result_t pending_results[$];

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				slot_key[i] = '0;
				slot_live[i] = 0;
				slot_gen[i] = '0;
				slot_refs[i] = '0;
				free_slots[i] = '0;
			end
			free_depth = 0;
			fresh_slot = 0;
			live_slots = 0;
			errors = 0;
		endfunction

		function ref_t inc_refs(ref_t c);
			return (c == '1) ? c : c + 1'b1;
		endfunction

		function void push_result(status_t s, idx_t ix, gen_t g);
			handle_result_t r;
			r.status = s;
			r.index = ix;
			r.generation = g;
			r.live = cnt_t'(live_slots);
			pending_results.insert(pending_results.size(), r);
		endfunction

		function void note_request(kind_t k, key_t dk, idx_t ix, gen_t g);
			int slot;
			if (k == KIND_GET) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_live[i] && slot_key[i] == dk) begin
						slot_refs[i] = inc_refs(slot_refs[i]);
						push_result(ST_REUSED, idx_t'(i), slot_gen[i]);
						return;
					end
				end
				if (free_depth > 0) begin
					free_depth--;
					slot = free_slots[free_depth];
				end else if (fresh_slot < SLOTS) begin
					slot = fresh_slot;
					fresh_slot++;
					slot_gen[slot] = '0;
				end else begin
					push_result(ST_FULL, '0, '0);
					return;
				end
				slot_key[slot] = dk;
				slot_live[slot] = 1;
				slot_refs[slot] = ref_t'(1);
				live_slots++;
				push_result(ST_CREATED, idx_t'(slot), slot_gen[slot]);
				return;
			end
			if (k != KIND_RETAIN && k != KIND_RELEASE || !slot_live[ix] || slot_gen[ix] != g) begin
				push_result(ST_INVALID, ix, g);
				return;
			end
			if (k == KIND_RETAIN) begin
				slot_refs[ix] = inc_refs(slot_refs[ix]);
				push_result(ST_RETAINED, ix, slot_gen[ix]);
				return;
			end
			if (slot_refs[ix] > 1) begin
				slot_refs[ix]--;
				push_result(ST_KEPT, ix, slot_gen[ix]);
				return;
			end
			slot_refs[ix] = '0;
			slot_key[ix] = '0;
			slot_live[ix] = 0;
			slot_gen[ix] = slot_gen[ix] + 1'b1;
			if (free_depth < SLOTS) begin
				free_slots[free_depth] = ix;
				free_depth++;
			end
			if (live_slots > 0)
				live_slots--;
			push_result(ST_FREED, ix, g);
		endfunction

		function void check_result(status_t s, idx_t ix, gen_t g, cnt_t n);
			handle_result_t e;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status=%0d index=%0d gen=%0d live=%0d",
					$time, s, ix, g, n);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			if (s !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, s);
				errors++;
			end
			if (ix !== e.index) begin
				$display("%0t: out_index expected %0d actual %0d", $time, e.index, ix);
				errors++;
			end
			if (g !== e.generation) begin
				$display("%0t: out_generation expected %0d actual %0d",
					$time, e.generation, g);
				errors++;
			end
			if (n !== e.live) begin
				$display("%0t: live_count expected %0d actual %0d", $time, e.live, n);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle;
	int   recv_stall;
	int   quiet_cycles;
	pool_scoreboard sb;

	hp_in_if  req_if();
	hp_out_if rsp_if();

	dedup_refcount_handle_pool_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in(req_if.sink),
		.out(rsp_if.source)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		req_if.valid = 0;
		req_if.kind = KIND_GET;
		req_if.desc_key = '0;
		req_if.slot_index = '0;
		req_if.slot_generation = '0;
		rsp_if.ready = 0;
	end

	always @(posedge clk) begin
		if (arst_n)
			rsp_if.ready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if (rsp_if.valid && rsp_if.ready && arst_n)
			sb.check_result(rsp_if.status, rsp_if.out_index, rsp_if.out_generation,
				rsp_if.live_count);
	end

	// watchdog: cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic send(kind_t k, key_t dk, idx_t ix, gen_t g);
		while ($urandom_range(99) < send_idle) begin
			req_if.valid <= 0;
			@(posedge clk);
		end
		req_if.valid <= 1;
		req_if.kind <= k;
		req_if.desc_key <= dk;
		req_if.slot_index <= ix;
		req_if.slot_generation <= g;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		sb.note_request(k, dk, ix, g);
	endtask

	function automatic key_t rand_key();
		return {$urandom, $urandom};
	endfunction

	// picks a live slot near a random start, or a random one if none is live
	function automatic idx_t pick_slot();
		int start;
		start = $urandom_range(SLOTS - 1);
		for (int i = 0; i < SLOTS; i++)
			if (sb.slot_live[(start + i) % SLOTS])
				return idx_t'((start + i) % SLOTS);
		return idx_t'(start);
	endfunction

	task automatic random_item(bit filling);
		int   roll;
		idx_t ix;
		gen_t g;
		key_t dk;
		roll = $urandom_range(99);
		ix = pick_slot();
		g = ($urandom_range(9) == 0) ? gen_t'($urandom) : sb.slot_gen[ix];
		if (roll < (filling ? 60 : 20)) begin
			roll = $urandom_range(9);
			if (roll < 4 && sb.slot_live[ix])
				dk = sb.slot_key[ix];
			else if (roll < 6)
				dk = key_t'($urandom_range(7));
			else
				dk = rand_key();
			send(KIND_GET, dk, ix, g);
		end else if (roll < (filling ? 75 : 40)) begin
			send(KIND_RETAIN, rand_key(), ix, g);
		end else if (roll < 95) begin
			send(KIND_RELEASE, rand_key(), ix, g);
		end else begin
			// noise: unknown kind or arbitrary handle
			roll = $urandom_range(2);
			send(roll == 0 ? kind_t'(2'd3) : (roll == 1 ? KIND_RETAIN : KIND_RELEASE),
				rand_key(), idx_t'($urandom), gen_t'($urandom));
		end
	endtask

	initial begin
		sb = new();
		send_idle = 19;
		recv_stall = 47;
		quiet_cycles = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: key zero, dedup, refcount up and down, stale handles, odd kind
		send(KIND_GET, '0, '0, '0);
		send(KIND_GET, '0, '1, '1);
		send(KIND_GET, '1, '0, '0);
		send(KIND_RETAIN, '0, 6'd0, 16'd0);
		send(KIND_RELEASE, '0, 6'd0, 16'd0);
		send(KIND_RELEASE, '0, 6'd0, 16'd0);
		send(KIND_RELEASE, '0, 6'd0, 16'd0);
		send(KIND_RELEASE, '0, 6'd0, 16'd0);
		send(KIND_RETAIN, '1, 6'd0, 16'd1);
		send(KIND_GET, 64'h8000_0000_0000_0005, '0, '0);
		send(KIND_RETAIN, '1, '1, '1);
		send(kind_t'(2'd3), '1, '1, '1);
		send(kind_t'(2'd3), '0, '0, '0);
		send(KIND_RELEASE, '0, 6'd1, 16'd1);
		send(KIND_RELEASE, '0, 6'd1, 16'd0);
		send(KIND_RETAIN, '0, 6'd2, 16'd0);
		send(KIND_RELEASE, '0, 6'd0, 16'd1);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 19 : (phase == 1 ? 47 : 0);
			recv_stall = (phase == 0) ? 47 : (phase == 1 ? 19 : 0);
			// alternate fill and drain runs of 160 random items each
			for (int n = 0; n < 480; n++)
				random_item(((n / 160) % 2) == 0);
		end

		req_if.valid <= 0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
